@@ rtl/gffra_pkg.sv @@
package gffra_pkg;

  localparam int unsigned MaxColsDef = 16;
  localparam int unsigned MaxRowsDef = 16;

  localparam logic [2:0] OP_CLEAR   = 3'd0;
  localparam logic [2:0] OP_MARK    = 3'd1;
  localparam logic [2:0] OP_FREE    = 3'd2;
  localparam logic [2:0] OP_TEST    = 3'd3;
  localparam logic [2:0] OP_FIND    = 3'd4;
  localparam logic [2:0] OP_RESERVE = 3'd5;

  localparam logic [0:0] CFG_COLS = 1'b0;
  localparam logic [0:0] CFG_ROWS = 1'b1;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] start_index;
    logic [4:0] item_width;
    logic [4:0] item_height;
  } req_t;

  typedef struct packed {
    logic       fit_found;
    logic [7:0] placement_index;
    logic       status;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // latch request, set up start position
    logic div_step;   // split start index: one row per step
    logic clr_start;  // begin clearing sweep
    logic clr_row;    // clear current row, advance
    logic chk_row;    // check current row of candidate, advance
    logic next_cand;  // advance candidate position
    logic wr_row;     // write current row (mark/free, or reserve after a find), advance
    logic rewind;     // rewind row pointer to candidate row
    logic set_fit;
    logic set_oob;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] op;
    logic       div_done;
    logic       in_bounds;
    logic       row_hit;
    logic       last_row;
    logic       cand_end;
  } sts_t;

endpackage

@@ rtl/gffra_ctrl.sv @@
module gffra_ctrl
  import gffra_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_CLR   = 3'd2;
  localparam logic [2:0] S_WR    = 3'd3;
  localparam logic [2:0] S_TEST  = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;
  localparam logic [2:0] S_RSV   = 3'd6;
  localparam logic [2:0] S_RSP   = 3'd7;

  logic [2:0] state_q, state_d;
  logic       reserve_q, reserve_d;

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = (state_q == S_RSP);

  always_comb begin
    state_d   = state_q;
    reserve_d = reserve_q;
    cmd_o     = '0;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        reserve_d = (sts_i.op == OP_RESERVE);
        if (!sts_i.div_done) begin
          cmd_o.div_step = 1'b1;
        end else begin
          case (sts_i.op)
            OP_CLEAR: begin
              cmd_o.clr_start = 1'b1;
              state_d         = S_CLR;
            end
            OP_MARK, OP_FREE: begin
              if (sts_i.in_bounds) begin
                state_d = S_WR;
              end else begin
                cmd_o.set_oob = 1'b1;
                state_d       = S_RSP;
              end
            end
            OP_TEST: begin
              if (sts_i.in_bounds) begin
                state_d = S_TEST;
              end else begin
                cmd_o.set_oob = 1'b1;
                state_d       = S_RSP;
              end
            end
            OP_FIND, OP_RESERVE: state_d = S_SCAN;
            default: state_d = S_RSP;
          endcase
        end
      end
      S_CLR: begin
        cmd_o.clr_row = 1'b1;
        if (sts_i.last_row) state_d = S_RSP;
      end
      S_WR: begin
        cmd_o.wr_row = 1'b1;
        if (sts_i.last_row) state_d = S_RSP;
      end
      S_TEST: begin
        if (sts_i.row_hit) begin
          state_d = S_RSP;
        end else begin
          cmd_o.chk_row = 1'b1;
          if (sts_i.last_row) begin
            cmd_o.set_fit = 1'b1;
            state_d       = S_RSP;
          end
        end
      end
      S_SCAN: begin
        if (sts_i.cand_end) begin
          state_d = S_RSP;
        end else if (!sts_i.in_bounds || sts_i.row_hit) begin
          cmd_o.next_cand = 1'b1;
        end else begin
          cmd_o.chk_row = 1'b1;
          if (sts_i.last_row) begin
            cmd_o.set_fit = 1'b1;
            if (reserve_q) begin
              cmd_o.rewind = 1'b1;
              state_d      = S_RSV;
            end else begin
              state_d = S_RSP;
            end
          end
        end
      end
      S_RSV: begin
        cmd_o.wr_row = 1'b1;
        if (sts_i.last_row) state_d = S_RSP;
      end
      S_RSP: begin
        if (rsp_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      reserve_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      reserve_q <= reserve_d;
    end
  end

endmodule

@@ rtl/gffra_dpath.sv @@
module gffra_dpath
  import gffra_pkg::*;
#(
  parameter int unsigned MaxCols = MaxColsDef,
  parameter int unsigned MaxRows = MaxRowsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic [4:0] grid_cols_i,
  input  logic [4:0] grid_rows_i,
  input  req_t req_i,
  input  cmd_t cmd_i,
  output sts_t sts_o,
  output rsp_t rsp_o
);

  localparam int unsigned RowW = (MaxRows > 1) ? $clog2(MaxRows) : 1;
  localparam int unsigned CW   = 7;

  logic [MaxCols-1:0] occ_q [MaxRows];

  req_t       req_q;
  logic [CW-1:0] col_q, row_q, cand_row_q, r_q;
  logic [8:0] cidx_q;
  logic [8:0] total_q;
  logic [8:0] rem_q;
  rsp_t       rsp_q;
  logic [CW-1:0] cols, rows;

  // Effective grid size
  always_comb begin
    cols = (grid_cols_i == 5'd0) ? CW'(1) : CW'(grid_cols_i);
    rows = (grid_rows_i == 5'd0) ? CW'(1) : CW'(grid_rows_i);
    if (cols > CW'(MaxCols)) cols = CW'(MaxCols);
    if (rows > CW'(MaxRows)) rows = CW'(MaxRows);
  end

  logic [CW:0] wend, hend;
  logic        inb;
  logic [MaxCols-1:0] mask;
  logic [MaxCols-1:0] cur_row;
  logic        hit;

  assign wend = {1'b0, col_q} + (CW+1)'(req_q.item_width);
  assign hend = {1'b0, cand_row_q} + (CW+1)'(req_q.item_height);
  assign inb  = (req_q.item_width != 5'd0) && (req_q.item_height != 5'd0) &&
                (cand_row_q < rows) && (wend <= {1'b0, cols}) &&
                (hend <= {1'b0, rows});

  always_comb begin
    for (int i = 0; i < MaxCols; i++) begin
      mask[i] = (CW'(i) >= col_q) && ((CW+1)'(i) < wend);
    end
  end

  // start tile split into row and column by repeated subtraction, one row a cycle
  logic [8:0] rem_nxt;
  assign rem_nxt = rem_q - {2'b0, cols};

  assign cur_row = occ_q[r_q[RowW-1:0]];
  assign hit     = |(cur_row & mask);

  assign sts_o.op        = req_q.operation;
  assign sts_o.div_done  = (rem_q < {2'b0, cols}) || (cand_row_q >= rows);
  assign sts_o.in_bounds = inb;
  assign sts_o.row_hit   = hit;
  assign sts_o.last_row  = (req_q.operation == OP_CLEAR) ? (r_q == CW'(MaxRows - 1))
                                                         : ((r_q + CW'(1)) == hend[CW-1:0]);
  assign sts_o.cand_end  = (cidx_q >= total_q);
  assign rsp_o           = rsp_q;

  logic [2*CW-1:0] tot;
  assign tot = {{CW{1'b0}}, cols} * {{CW{1'b0}}, rows};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxRows; i++) occ_q[i] <= '0;
    end else begin
      if (cmd_i.clr_row) occ_q[r_q[RowW-1:0]] <= '0;
      if (cmd_i.wr_row) begin
        if (req_q.operation == OP_FREE) occ_q[r_q[RowW-1:0]] <= cur_row & ~mask;
        else occ_q[r_q[RowW-1:0]] <= cur_row | mask;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q      <= req_i;
      total_q    <= (tot > (2*CW)'(256)) ? 9'd256 : tot[8:0];
      rsp_q      <= '0;
      cand_row_q <= '0;
      r_q        <= '0;
      if (req_i.operation == OP_MARK || req_i.operation == OP_FREE ||
          req_i.operation == OP_TEST) begin
        col_q  <= req_i.start_index[CW-1:0];
        rem_q  <= {1'b0, req_i.start_index};
        cidx_q <= {1'b0, req_i.start_index};
      end else begin
        col_q <= '0; rem_q <= '0; cidx_q <= '0;
      end
    end
    if (cmd_i.div_step) begin
      rem_q      <= rem_nxt;
      col_q      <= rem_nxt[CW-1:0];
      cand_row_q <= cand_row_q + CW'(1);
    end
    if (cmd_i.clr_start) r_q <= '0;
    if (cmd_i.clr_row || cmd_i.wr_row || cmd_i.chk_row || cmd_i.div_step) r_q <= r_q + CW'(1);
    if (cmd_i.rewind) r_q <= cand_row_q;
    if (cmd_i.next_cand) begin
      cidx_q <= cidx_q + 9'd1;
      if ((col_q + CW'(1)) == cols) begin
        col_q      <= '0;
        cand_row_q <= cand_row_q + CW'(1);
        r_q        <= cand_row_q + CW'(1);
      end else begin
        col_q <= col_q + CW'(1);
        r_q   <= cand_row_q;
      end
    end
    if (cmd_i.set_oob) rsp_q.status <= 1'b1;
    if (cmd_i.set_fit) begin
      rsp_q.fit_found       <= 1'b1;
      rsp_q.placement_index <= cidx_q[7:0];
    end
  end

endmodule

@@ rtl/grid_first_fit_rect_allocator.sv @@
// Request taken to response offered: the start tile is first split into row and column;
// then mark, free and test walk the rectangle's rows, and clear walks every map row.
// Find: tiles are tried in order, each candidate's rows checked; reserve then writes its rows.
// Throughput: one request at a time; the next is taken the cycle after the response.
// Reset: map all free, grid 8 by 8, no response pending.
module grid_first_fit_rect_allocator
  import gffra_pkg::*;
#(
  parameter int unsigned MaxCols = MaxColsDef,
  parameter int unsigned MaxRows = MaxRowsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  input  req_t       req_i,
  output logic       rsp_valid_o,
  input  logic       rsp_ready_i,
  output rsp_t       rsp_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [0:0] cfg_index_i,
  input  logic [4:0] cfg_data_i
);

  logic [4:0] cols_q, rows_q;
  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= 5'd8;
      rows_q <= 5'd8;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_COLS) cols_q <= cfg_data_i;
      else rows_q <= cfg_data_i;
    end
  end

  gffra_ctrl u_ctrl (
    .clk_i, .rst_ni, .req_valid_i, .req_ready_o, .rsp_valid_o, .rsp_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  gffra_dpath #(.MaxCols(MaxCols), .MaxRows(MaxRows)) u_dpath (
    .clk_i, .rst_ni, .grid_cols_i(cols_q), .grid_rows_i(rows_q),
    .req_i, .cmd_i(cmd), .sts_o(sts), .rsp_o
  );

`ifndef SYNTHESIS
  a_no_req_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !req_ready_o) else $error("accepting while responding");
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("response dropped");
  a_fit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !(rsp_o.fit_found && rsp_o.status)) else $error("fit and oob");
`endif

endmodule

@@ tb/grid_first_fit_rect_allocator_tb.sv @@
`timescale 1ns / 100ps

module grid_first_fit_rect_allocator_tb;
  import gffra_pkg::*;

  localparam int unsigned WatchLimit = 40000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       req_valid_i = 1'b0;
  logic       req_ready_o;
  req_t       req_i = '0;
  logic       rsp_valid_o;
  logic       rsp_ready_i = 1'b0;
  rsp_t       rsp_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [0:0] cfg_index_i = '0;
  logic [4:0] cfg_data_i = '0;

  grid_first_fit_rect_allocator dut (.*);

  always #2 clk_i = ~clk_i;

  logic [15:0] occ_map [16];
  logic [4:0]  cols_reg, rows_reg;
  rsp_t        expected_rsps [$];
  int unsigned n_errors = 0;
  int unsigned idle_cycles = 0;
  bit          rsp_calm = 1'b0;
  bit          rsp_hold = 1'b0;

  function automatic int unsigned grid_cols_used();
    if (cols_reg == 0) return 1;
    if (cols_reg > 16) return 16;
    return cols_reg;
  endfunction

  function automatic int unsigned grid_rows_used();
    if (rows_reg == 0) return 1;
    if (rows_reg > 16) return 16;
    return rows_reg;
  endfunction

  function automatic bit rect_inside(int unsigned idx, int unsigned w, int unsigned h);
    int unsigned c, r;
    c = grid_cols_used();
    r = grid_rows_used();
    if (w == 0 || h == 0 || idx >= c * r) return 1'b0;
    return (idx % c) + w <= c && (idx / c) + h <= r;
  endfunction

  function automatic logic [15:0] span_bits(int unsigned col, int unsigned w);
    logic [31:0] m;
    m = ((32'd1 << w) - 1) << col;
    return m[15:0];
  endfunction

  function automatic bit rect_free(int unsigned idx, int unsigned w, int unsigned h);
    int unsigned c;
    logic [15:0] m;
    if (!rect_inside(idx, w, h)) return 1'b0;
    c = grid_cols_used();
    m = span_bits(idx % c, w);
    for (int unsigned r = idx / c; r < idx / c + h; r++)
      if ((occ_map[r] & m) != 0) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void paint_rect(int unsigned idx, int unsigned w, int unsigned h,
                                     bit occ);
    int unsigned c;
    logic [15:0] m;
    c = grid_cols_used();
    m = span_bits(idx % c, w);
    for (int unsigned r = idx / c; r < idx / c + h; r++)
      occ_map[r] = occ ? (occ_map[r] | m) : (occ_map[r] & ~m);
  endfunction

  function automatic rsp_t predict_alloc(req_t q);
    rsp_t o;
    int unsigned total;
    o = '0;
    case (q.operation)
      OP_CLEAR: foreach (occ_map[i]) occ_map[i] = '0;
      OP_MARK, OP_FREE: begin
        if (rect_inside(q.start_index, q.item_width, q.item_height))
          paint_rect(q.start_index, q.item_width, q.item_height, q.operation == OP_MARK);
        else o.status = 1'b1;
      end
      OP_TEST: begin
        if (!rect_inside(q.start_index, q.item_width, q.item_height)) o.status = 1'b1;
        else if (rect_free(q.start_index, q.item_width, q.item_height)) begin
          o.fit_found = 1'b1;
          o.placement_index = q.start_index;
        end
      end
      OP_FIND, OP_RESERVE: begin
        total = grid_cols_used() * grid_rows_used();
        if (total > 256) total = 256;
        for (int unsigned c = 0; c < total; c++) begin
          if (rect_free(c, q.item_width, q.item_height)) begin
            o.fit_found = 1'b1;
            o.placement_index = c[7:0];
            if (q.operation == OP_RESERVE) paint_rect(c, q.item_width, q.item_height, 1'b1);
            break;
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  // response sampling and comparison
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && rsp_valid_o && rsp_ready_i) begin
      if (expected_rsps.size() == 0) report_mismatch("unexpected response", 1, 0);
      else begin
        want = expected_rsps.pop_front();
        if (rsp_o.fit_found !== want.fit_found)
          report_mismatch("fit_found", rsp_o.fit_found, want.fit_found);
        if (rsp_o.placement_index !== want.placement_index)
          report_mismatch("placement_index", rsp_o.placement_index, want.placement_index);
        if (rsp_o.status !== want.status)
          report_mismatch("status", rsp_o.status, want.status);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((req_valid_i && req_ready_o) || (rsp_valid_o && rsp_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (!rst_ni) rsp_ready_i <= 1'b0;
    else rsp_ready_i <= !rsp_hold && (rsp_calm || $urandom_range(99) >= 16);
  end

  // typed rows carry their expected response; the predictor still tracks the map
  task automatic send_request(req_t q, bit typed = 1'b0, rsp_t want = '0);
    rsp_t got;
    while (!rsp_calm && $urandom_range(99) < 16) begin
      req_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    req_i <= q;
    req_valid_i <= 1'b1;
    do @(posedge clk_i); while (!req_ready_o);
    got = predict_alloc(q);
    expected_rsps.push_back(typed ? want : got);
    @(negedge clk_i);
  endtask

  task automatic drain_responses();
    req_valid_i <= 1'b0;
    while (expected_rsps.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
  endtask

  task automatic write_grid(logic [0:0] idx, logic [4:0] val);
    drain_responses();
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_COLS) cols_reg = val;
    else rows_reg = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // rectangles mostly small with the start tile inside the grid; some wild
  function automatic req_t random_request();
    req_t q;
    int unsigned c, r, k;
    c = grid_cols_used();
    r = grid_rows_used();
    k = $urandom_range(99);
    q.operation = (k < 30) ? OP_MARK : (k < 45) ? OP_FREE : (k < 65) ? OP_TEST :
                  (k < 78) ? OP_FIND : (k < 93) ? OP_RESERVE : (k < 96) ? OP_CLEAR :
                  3'($urandom_range(7));
    if ($urandom_range(9) < 8) begin
      q.start_index = 8'($urandom_range(c * r - 1));
      q.item_width = 5'($urandom_range(1, (c < 4) ? c : 4));
      q.item_height = 5'($urandom_range(1, (r < 4) ? r : 4));
    end else begin
      q.start_index = 8'($urandom);
      q.item_width = 5'($urandom);
      q.item_height = 5'($urandom);
    end
    return q;
  endfunction

  typedef struct {
    req_t req;
    bit   typed;
    rsp_t want;
  } stim_row_t;

  stim_row_t directed [] = '{
    '{'{OP_FIND, 8'd0, 5'd8, 5'd8}, 1'b1, '{1'b1, 8'd0, 1'b0}},
    '{'{OP_TEST, 8'd0, 5'd9, 5'd1}, 1'b1, '{1'b0, 8'd0, 1'b1}},
    '{'{OP_MARK, 8'd255, 5'd1, 5'd1}, 1'b1, '{1'b0, 8'd0, 1'b1}},
    '{'{OP_MARK, 8'd0, 5'd0, 5'd1}, 1'b1, '{1'b0, 8'd0, 1'b1}},
    '{'{OP_FREE, 8'd0, 5'd1, 5'd0}, 1'b1, '{1'b0, 8'd0, 1'b1}},
    '{'{OP_TEST, 8'd0, 5'd31, 5'd31}, 1'b1, '{1'b0, 8'd0, 1'b1}},
    '{'{OP_RESERVE, 8'd0, 5'd8, 5'd8}, 1'b1, '{1'b1, 8'd0, 1'b0}},
    '{'{OP_FIND, 8'd0, 5'd1, 5'd1}, 1'b1, '{1'b0, 8'd0, 1'b0}},
    '{'{OP_CLEAR, 8'd0, 5'd0, 5'd0}, 1'b1, '{1'b0, 8'd0, 1'b0}},
    '{'{3'd6, 8'd255, 5'd31, 5'd31}, 1'b1, '{1'b0, 8'd0, 1'b0}},
    '{'{3'd7, 8'd170, 5'd21, 5'd10}, 1'b1, '{1'b0, 8'd0, 1'b0}},
    '{'{OP_MARK, 8'd9, 5'd2, 5'd2}, 1'b0, '0},
    '{'{OP_TEST, 8'd9, 5'd1, 5'd1}, 1'b0, '0},
    '{'{OP_TEST, 8'd63, 5'd1, 5'd1}, 1'b0, '0},
    '{'{OP_RESERVE, 8'd0, 5'd3, 5'd2}, 1'b0, '0},
    '{'{OP_FIND, 8'd0, 5'd2, 5'd2}, 1'b0, '0},
    '{'{OP_FREE, 8'd10, 5'd1, 5'd1}, 1'b0, '0},
    '{'{OP_TEST, 8'd7, 5'd2, 5'd1}, 1'b0, '0},
    '{'{OP_FIND, 8'd85, 5'd16, 5'd16}, 1'b0, '0}
  };

  initial begin
    logic [4:0] grid_steps [] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd12, 5'd3, 5'd16};
    foreach (occ_map[i]) occ_map[i] = '0;
    cols_reg = 5'd8;
    rows_reg = 5'd8;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) begin
      send_request(directed[i].req, directed[i].typed, directed[i].want);
    end

    foreach (grid_steps[p]) begin
      write_grid(CFG_COLS, grid_steps[p]);
      write_grid(CFG_ROWS, grid_steps[(p + 3) % grid_steps.size()]);
      rsp_calm = (p == 2);
      if (p == 4) fork
        begin
          rsp_hold = 1'b1;
          repeat (400) @(negedge clk_i);
          rsp_hold = 1'b0;
        end
      join_none
      for (int n = 0; n < 130; n++) begin
        send_request(random_request());
        if (n == 60) drain_responses();
      end
      rsp_calm = 1'b0;
    end

    drain_responses();
    if (n_errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
